>>> design/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// Types, constants and decode helpers shared by the UTF-8 to UTF-16
// transcoder and its channel interfaces.
// ----------------------------------------------------------------------------
package u8u16_pkg;

    // Code unit sent for a byte that cannot be decoded.
    localparam logic [15:0] C_HASH_UNIT  = 16'h0023;
    localparam logic [20:0] C_PLANE1     = 21'h10000;
    localparam logic [15:0] C_HI_SURR    = 16'hD800;
    localparam logic [15:0] C_LO_SURR    = 16'hDC00;
    localparam logic [9:0]  C_SURR_MASK  = 10'h3FF;
    localparam logic [5:0]  C_CONT_MASK  = 6'h3F;

    typedef logic [7:0]       t_byte;
    typedef logic [15:0]      t_unit;
    typedef logic [20:0]      t_cp;
    typedef logic [2:0]       t_len;
    typedef logic [3:0][7:0]  t_bytes4;

    // One or two code units that carry a single code point.
    typedef struct packed {
        t_unit hi;
        t_unit lo;
        logic  two;
    } t_units;

    // Sequence length from the top five bits of a lead byte; zero marks a
    // stray continuation byte or an 11111xxx byte.
    function automatic t_len seq_len(input logic [4:0] top);
        t_len l;
        if (!top[4]) begin
            l = 3'd1;
        end else if (!top[3]) begin
            l = 3'd0;
        end else if (!top[2]) begin
            l = 3'd2;
        end else if (!top[1]) begin
            l = 3'd3;
        end else if (!top[0]) begin
            l = 3'd4;
        end else begin
            l = 3'd0;
        end
        return l;
    endfunction

    // Payload bits kept from a lead byte for a given length.
    function automatic t_byte lead_mask(input t_len l);
        t_byte m;
        unique case (l)
            3'd1:    m = 8'h7F;
            3'd2:    m = 8'h1F;
            3'd3:    m = 8'h0F;
            3'd4:    m = 8'h07;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

    // Decode a sequence of length l (1 to 4) starting at b[0]. Following
    // bytes contribute their low six bits unchecked.
    function automatic t_cp decode_seq(input t_bytes4 b, input t_len l);
        t_cp cp;
        cp = t_cp'(b[0] & lead_mask(l));
        for (int i = 1; i < 4; i++) begin
            if (3'(i) < l) begin
                cp = {cp[14:0], b[i][5:0] & C_CONT_MASK};
            end
        end
        return cp;
    endfunction

    // Split a code point into one unit or a surrogate pair.
    function automatic t_units cp_units(input t_cp cp);
        t_units u;
        t_cp    d;
        d = cp - C_PLANE1;
        if (cp < C_PLANE1) begin
            u.hi  = cp[15:0];
            u.lo  = 16'h0000;
            u.two = 1'b0;
        end else begin
            u.hi  = 16'(d[20:10]) + C_HI_SURR;
            u.lo  = 16'(d[9:0] & C_SURR_MASK) + C_LO_SURR;
            u.two = 1'b1;
        end
        return u;
    endfunction

endpackage

>>> design/u8u16_in_if.sv
// ----------------------------------------------------------------------------
// u8u16_in_if
// Input channel: one UTF-8 byte per item with its end-of-stream flag.
// ----------------------------------------------------------------------------
interface u8u16_in_if import u8u16_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte in_byte;
    logic  stream_end;

    modport source (output valid, output in_byte, output stream_end, input ready);
    modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

>>> design/u8u16_out_if.sv
// ----------------------------------------------------------------------------
// u8u16_out_if
// Output channel: one UTF-16 code unit per item with its framing flags.
// ----------------------------------------------------------------------------
interface u8u16_out_if import u8u16_pkg::*; ();
    logic  valid;
    logic  ready;
    t_unit code_unit;
    logic  run_last;
    logic  stream_done;

    modport source (output valid, output code_unit, output run_last,
                    output stream_done, input ready);
    modport sink   (input valid, input code_unit, input run_last,
                    input stream_done, output ready);
endinterface

>>> design/utf8_to_utf16_transcoder.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// Converts a UTF-8 byte stream into UTF-16 code units, one byte per item.
// ----------------------------------------------------------------------------
// An accepted byte goes through the input register, its code units through
// the result register. One byte per cycle unless a held bundle is not yet all
// taken; a byte yields up to 3 units (on the end-of-stream flush).
// Reset (synchronous, active low) empties the input and result registers and
// clears the pending sequence count and length.
module utf8_to_utf16_transcoder import u8u16_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    u8u16_in_if.sink    i_in,
    u8u16_out_if.source o_out
);

    // Input register.
    logic  r_in_vld;
    t_byte r_in_byte;
    logic  r_in_end;

    // Pending sequence state.
    t_byte      r_pend [3];
    logic [1:0] r_pend_cnt;
    t_len       r_exp_len;

    // Result register: up to three units, shifted out from entry zero.
    t_unit      r_q [3];
    logic [1:0] r_q_cnt;
    logic       r_q_end;
    logic       r_q_vld;

    // Decode results for the item in the input register.
    t_unit      n_q [3];
    logic [1:0] n_q_cnt;
    logic [1:0] n_pend_cnt;
    t_len       n_exp_len;
    logic       n_pend_wr;

    logic out_take;
    logic res_free;
    logic advance;

    t_bytes4 buf4;
    t_len    n_len;

    // Handshake control.
    assign out_take   = o_out.valid && o_out.ready;
    assign res_free   = !r_q_vld || (out_take && (r_q_cnt == 2'd1));
    assign advance    = r_in_vld && ((n_q_cnt == 2'd0) || res_free);
    assign i_in.ready = !r_in_vld || advance;

    // Input register load.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.in_byte;
            r_in_end  <= i_in.stream_end;
        end
    end

    // Decode the buffered sequence plus the new byte.
    always_comb begin
        t_len       l;
        t_len       left;
        t_len       pos;
        t_units     su;
        t_bytes4    win;
        logic [1:0] cnt;

        buf4[0] = r_pend[0];
        buf4[1] = r_pend[1];
        buf4[2] = r_pend[2];
        buf4[3] = 8'h00;
        buf4[r_pend_cnt] = r_in_byte;
        n_len = {1'b0, r_pend_cnt} + 3'd1;

        n_q[0]     = C_HASH_UNIT;
        n_q[1]     = C_HASH_UNIT;
        n_q[2]     = C_HASH_UNIT;
        cnt        = 2'd0;
        n_pend_cnt = r_pend_cnt;
        n_exp_len  = r_exp_len;
        n_pend_wr  = 1'b0;
        pos        = 3'd0;
        l          = 3'd0;
        left       = 3'd0;
        su         = '0;
        win        = '0;

        if (r_in_end) begin
            // Flush: decode what is buffered from the start, one step per byte
            // position; a non-lead byte or an unfit lead yields the hash unit.
            for (int p = 0; p < 4; p++) begin
                if ((3'(p) < n_len) && (3'(p) == pos)) begin
                    l    = seq_len(buf4[p][7:3]);
                    left = n_len - 3'(p);
                    for (int i = 0; i < 4; i++) begin
                        win[i] = (p + i < 4) ? buf4[2'(p + i)] : 8'h00;
                    end
                    if ((l == 3'd0) || (l > left)) begin
                        su.hi  = C_HASH_UNIT;
                        su.lo  = 16'h0000;
                        su.two = 1'b0;
                        pos    = 3'(p) + 3'd1;
                    end else begin
                        su  = cp_units(decode_seq(win, l));
                        pos = 3'(p) + l;
                    end
                    if (cnt != 2'd3) begin
                        n_q[cnt] = su.hi;
                        cnt      = cnt + 2'd1;
                    end
                    if (su.two && (cnt != 2'd3)) begin
                        n_q[cnt] = su.lo;
                        cnt      = cnt + 2'd1;
                    end
                end
            end
            n_pend_cnt = 2'd0;
            n_exp_len  = 3'd0;
        end else if (r_pend_cnt == 2'd0) begin
            // Lead byte: ASCII and bad leads go out now, longer forms wait.
            l = seq_len(r_in_byte[7:3]);
            if (l == 3'd0) begin
                n_q[0] = C_HASH_UNIT;
                cnt    = 2'd1;
            end else if (l == 3'd1) begin
                n_q[0] = {8'h00, r_in_byte};
                cnt    = 2'd1;
            end else begin
                n_pend_wr  = 1'b1;
                n_pend_cnt = 2'd1;
                n_exp_len  = l;
            end
        end else if ((n_len >= r_exp_len) || (n_len == 3'd4)) begin
            // Sequence complete.
            l = ((r_exp_len < 3'd2) || (r_exp_len > 3'd4)) ? n_len : r_exp_len;
            su = cp_units(decode_seq(buf4, l));
            n_q[0] = su.hi;
            n_q[1] = su.lo;
            cnt    = su.two ? 2'd2 : 2'd1;
            n_pend_cnt = 2'd0;
            n_exp_len  = 3'd0;
        end else begin
            // Still short: keep buffering.
            n_pend_wr  = 1'b1;
            n_pend_cnt = n_len[1:0];
        end
        n_q_cnt = cnt;
    end

    // Pending sequence state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_cnt <= 2'd0;
            r_exp_len  <= 3'd0;
        end else if (advance) begin
            r_pend_cnt <= n_pend_cnt;
            r_exp_len  <= n_exp_len;
        end
        if (advance && n_pend_wr) begin
            r_pend[r_pend_cnt] <= r_in_byte;
        end
    end

    // Result register: load a new bundle or shift out the unit just taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_vld <= 1'b0;
            r_q_cnt <= 2'd0;
        end else if (advance && (n_q_cnt != 2'd0)) begin
            r_q_vld <= 1'b1;
            r_q_cnt <= n_q_cnt;
        end else if (out_take) begin
            r_q_vld <= (r_q_cnt != 2'd1);
            r_q_cnt <= r_q_cnt - 2'd1;
        end
        if (advance && (n_q_cnt != 2'd0)) begin
            r_q[0]  <= n_q[0];
            r_q[1]  <= n_q[1];
            r_q[2]  <= n_q[2];
            r_q_end <= r_in_end;
        end else if (out_take) begin
            r_q[0] <= r_q[1];
            r_q[1] <= r_q[2];
        end
    end

    // Output channel.
    assign o_out.valid       = r_q_vld;
    assign o_out.code_unit   = r_q[0];
    assign o_out.run_last    = (r_q_cnt == 2'd1);
    assign o_out.stream_done = (r_q_cnt == 2'd1) && r_q_end;

    // A held result bundle always has at least one unit left.
    a_cnt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_vld |-> (r_q_cnt != 2'd0))
        else $error("result register valid with no units");

    // A buffered sequence is always shorter than its expected length.
    a_pend_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_cnt != 2'd0) |-> ({1'b0, r_pend_cnt} < r_exp_len))
        else $error("pending count reached expected length");

    // The final byte of a stream always leaves the buffer empty.
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_end) |=> ((r_pend_cnt == 2'd0) && (r_exp_len == 3'd0)))
        else $error("pending state kept after stream end");

    // The final byte of a stream always produces at least one unit.
    a_end_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_end) |-> (n_q_cnt != 2'd0))
        else $error("stream end produced no unit");

endmodule

>>> sim/utf8_to_utf16_transcoder_tb.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_tb
// Self-checking bench for the UTF-8 to UTF-16 transcoder. A table of
// directed bytes covers the range extremes, every sequence length, overlong
// and surrogate forms, codes beyond U+10FFFF and the end-of-stream flush.
// Random byte streams follow, mostly well-formed characters with random
// payload mixed with noise and broken sequences. The bench runs them under
// four idling mixes. Every code unit is compared with the units typed in the
// table or with a local transcoder model that runs on each accepted byte.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_tb;
    import u8u16_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_UNITS   = 3;
    localparam int LONG_HOLD   = 60;
    localparam int TAIL_CYCLES = 8;
    localparam int N_DIRECTED  = 26;

    // One expected code unit with its framing flags.
    typedef struct packed {
        t_unit unit;
        logic  last;
        logic  done;
    } t_unit_exp;

    // One stimulus byte; n_typed > 0 gives the expected units directly.
    typedef struct packed {
        t_byte      in_byte;
        logic       stream_end;
        logic [1:0] n_typed;
        t_unit      u0;
        t_unit      u1;
        t_unit      u2;
    } t_byte_row;

    // Directed bytes. Rows with n_typed = 0 are checked by the model.
    localparam t_byte_row DIRECTED [N_DIRECTED] = '{
        '{8'h00, 1'b0, 2'd1, 16'h0000, 16'h0000, 16'h0000}, // smallest byte
        '{8'h7F, 1'b0, 2'd1, 16'h007F, 16'h0000, 16'h0000}, // largest ASCII
        '{8'h80, 1'b0, 2'd1, 16'h0023, 16'h0000, 16'h0000}, // stray continuation
        '{8'hFF, 1'b0, 2'd1, 16'h0023, 16'h0000, 16'h0000}, // 11111xxx lead
        '{8'hC2, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000}, // two-byte form
        '{8'hA9, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000},
        '{8'hF0, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000}, // four bytes, pair
        '{8'h9F, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000},
        '{8'h98, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000},
        '{8'h80, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000},
        '{8'hF7, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000}, // beyond U+10FFFF
        '{8'hBF, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000},
        '{8'hBF, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000},
        '{8'hBF, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000},
        '{8'hC0, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000}, // overlong NUL
        '{8'h80, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000},
        '{8'hED, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000}, // surrogate code point
        '{8'hA0, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000},
        '{8'h80, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000},
        '{8'hC3, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000}, // follower is ASCII
        '{8'h41, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000},
        '{8'h41, 1'b1, 2'd1, 16'h0041, 16'h0000, 16'h0000}, // end on a plain byte
        '{8'hF0, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000}, // end cuts a 4-byte form
        '{8'h9F, 1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000},
        '{8'h98, 1'b1, 2'd3, 16'h0023, 16'h0023, 16'h0023},
        '{8'hC2, 1'b1, 2'd1, 16'h0023, 16'h0000, 16'h0000}  // end on a lone lead
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    u8u16_in_if  u8_in ();
    u8u16_out_if u16_out ();

    utf8_to_utf16_transcoder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (u8_in),
        .o_out   (u16_out)
    );

    always #1 i_clk = ~i_clk;

    // Model state: bytes of an unfinished sequence and its length.
    t_byte held_bytes [3];
    int    held_count = 0;
    t_len  held_len   = 3'd0;

    t_byte     seq_bytes [$];
    t_unit     step_units [$];
    t_unit_exp expected_units [$];

    int error_count   = 0;
    int bytes_sent    = 0;
    int ends_sent     = 0;
    int units_checked = 0;
    int pairs_seen    = 0;

    int   send_idle_pct = 0;
    int   rx_stall_pct  = 0;
    logic hold_request  = 1'b0;

    // Sequence length from a lead byte; zero for a byte that cannot lead.
    function automatic t_len utf8_len(input t_byte b);
        casez (b)
            8'b0???????: return 3'd1;
            8'b110?????: return 3'd2;
            8'b1110????: return 3'd3;
            8'b11110???: return 3'd4;
            default:     return 3'd0;
        endcase
    endfunction

    // Code point of the len bytes at pos; followers give their low six bits.
    function automatic t_cp join_bits(input int pos, input t_len len);
        t_cp   cp;
        t_byte keep;
        case (len)
            3'd1:    keep = 8'h7F;
            3'd2:    keep = 8'h1F;
            3'd3:    keep = 8'h0F;
            default: keep = 8'h07;
        endcase
        cp = t_cp'(seq_bytes[pos] & keep);
        for (int i = 1; i < int'(len); i++) begin
            cp = (cp << 6) | t_cp'(seq_bytes[pos + i][5:0]);
        end
        return cp;
    endfunction

    // A code point leaves as one unit, or as a pair from U+10000 upward.
    function automatic void emit_codepoint(input t_cp cp);
        t_cp d;
        if (cp < C_PLANE1) begin
            step_units.push_back(cp[15:0]);
        end else begin
            d = cp - C_PLANE1;
            step_units.push_back(t_unit'(d >> 10) + C_HI_SURR);
            step_units.push_back(t_unit'(d[9:0]) + C_LO_SURR);
            pairs_seen++;
        end
    endfunction

    // Units caused by one accepted byte; updates the held sequence.
    function automatic void transcode_byte(input t_byte b, input logic e);
        int   n;
        int   pos;
        t_len l;
        step_units.delete();
        seq_bytes.delete();
        for (pos = 0; pos < held_count; pos++) begin
            seq_bytes.push_back(held_bytes[pos]);
        end
        seq_bytes.push_back(b);
        n = seq_bytes.size();
        if (e) begin
            // Flush: a non-lead byte or a lead longer than what is left yields '#'.
            pos = 0;
            while (pos < n) begin
                l = utf8_len(seq_bytes[pos]);
                if (l == 3'd0 || int'(l) > n - pos) begin
                    step_units.push_back(C_HASH_UNIT);
                    pos++;
                end else begin
                    emit_codepoint(join_bits(pos, l));
                    pos += int'(l);
                end
            end
            held_count = 0;
            held_len   = 3'd0;
        end else if (n == 1) begin
            l = utf8_len(b);
            if (l == 3'd0) begin
                step_units.push_back(C_HASH_UNIT);
            end else if (l == 3'd1) begin
                step_units.push_back({8'h00, b});
            end else begin
                held_bytes[0] = b;
                held_count    = 1;
                held_len      = l;
            end
        end else if (n >= int'(held_len) || n >= 4) begin
            l = held_len;
            if (l < 3'd2 || l > 3'd4) begin
                l = t_len'(n);
            end
            emit_codepoint(join_bits(0, l));
            held_count = 0;
            held_len   = 3'd0;
        end else begin
            held_bytes[n - 1] = b;
            held_count        = n;
        end
        while (step_units.size() > MAX_UNITS) begin
            step_units.pop_back();
        end
    endfunction

    // Offers one byte; entered and left at a falling edge with valid free.
    task automatic send_byte(input t_byte_row r);
        t_unit_exp want;
        int        k;
        while ($urandom_range(99) < send_idle_pct) begin
            u8_in.valid <= 1'b0;
            @(negedge i_clk);
        end
        u8_in.valid      <= 1'b1;
        u8_in.in_byte    <= r.in_byte;
        u8_in.stream_end <= r.stream_end;
        do @(posedge i_clk); while (!u8_in.ready);
        transcode_byte(r.in_byte, r.stream_end);
        if (r.n_typed != 2'd0) begin
            step_units.delete();
            for (k = 0; k < int'(r.n_typed); k++) begin
                step_units.push_back(k == 0 ? r.u0 : (k == 1 ? r.u1 : r.u2));
            end
        end
        for (k = 0; k < step_units.size(); k++) begin
            want.unit = step_units[k];
            want.last = (k == step_units.size() - 1);
            want.done = want.last && r.stream_end;
            expected_units.push_back(want);
        end
        bytes_sent++;
        if (r.stream_end) begin
            ends_sent++;
        end
        @(negedge i_clk);
    endtask

    // Stops offering and waits until every expected unit has come out.
    task automatic wait_for_units();
        u8_in.valid <= 1'b0;
        while (expected_units.size() != 0) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // Random lead byte for a sequence of two to four bytes.
    function automatic t_byte random_lead(input int len);
        case (len)
            2:       return 8'hC0 | t_byte'($urandom_range(0, 31));
            3:       return 8'hE0 | t_byte'($urandom_range(0, 15));
            default: return 8'hF0 | t_byte'($urandom_range(0, 7));
        endcase
    endfunction

    // Random stream: mostly well-formed characters, some noise and cut-off
    // sequences, and now and then a stream end inside or after a character.
    task automatic send_random(input int count);
        t_byte     chunk [$];
        t_byte_row r;
        int        kind;
        int        len;
        int        cut;
        int        k;
        int        sent;
        logic      fin;
        sent = 0;
        while (sent < count) begin
            chunk.delete();
            kind = $urandom_range(99);
            fin  = 1'b0;
            if (kind < 72) begin
                len = $urandom_range(1, 4);
                if (len == 1) begin
                    chunk.push_back(t_byte'($urandom_range(0, 127)));
                end else begin
                    chunk.push_back(random_lead(len));
                end
                for (k = 1; k < len; k++) begin
                    if ($urandom_range(9) == 0) begin
                        chunk.push_back(t_byte'($urandom));
                    end else begin
                        chunk.push_back(8'h80 | t_byte'($urandom_range(0, 63)));
                    end
                end
                if ($urandom_range(14) == 0) begin
                    fin = 1'b1;
                end else if (len > 1 && $urandom_range(19) == 0) begin
                    cut = $urandom_range(1, len - 1);
                    while (chunk.size() > cut) begin
                        chunk.pop_back();
                    end
                    fin = 1'b1;
                end
            end else if (kind < 88) begin
                chunk.push_back(t_byte'($urandom));
                fin = ($urandom_range(9) == 0);
            end else begin
                // Cut-off sequence: the next character's bytes complete it.
                len = $urandom_range(2, 4);
                chunk.push_back(random_lead(len));
                cut = $urandom_range(0, len - 2);
                for (k = 0; k < cut; k++) begin
                    chunk.push_back(8'h80 | t_byte'($urandom_range(0, 63)));
                end
            end
            for (k = 0; k < chunk.size(); k++) begin
                r            = '0;
                r.in_byte    = chunk[k];
                r.stream_end = fin && (k == chunk.size() - 1);
                send_byte(r);
                sent++;
            end
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin : unit_sink
        int held;
        u16_out.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request <= 1'b0;
                for (held = 0; held < LONG_HOLD; held++) begin
                    u16_out.ready <= 1'b0;
                    @(negedge i_clk);
                end
            end
            u16_out.ready <= ($urandom_range(99) < rx_stall_pct) ? 1'b0 : 1'b1;
        end
    end

    // Each accepted unit against the oldest expectation.
    always @(posedge i_clk) begin : unit_check
        t_unit_exp want;
        if (i_rst_n && u16_out.valid && u16_out.ready) begin
            units_checked++;
            if (expected_units.size() == 0) begin
                error_count++;
                $display("%0t: unexpected unit %h, none expected", $realtime,
                         u16_out.code_unit);
            end else begin
                want = expected_units.pop_front();
                if (u16_out.code_unit !== want.unit) begin
                    error_count++;
                    $display("%0t: code_unit expected %h, got %h", $realtime,
                             want.unit, u16_out.code_unit);
                end
                if (u16_out.run_last !== want.last) begin
                    error_count++;
                    $display("%0t: run_last expected %b, got %b", $realtime,
                             want.last, u16_out.run_last);
                end
                if (u16_out.stream_done !== want.done) begin
                    error_count++;
                    $display("%0t: stream_done expected %b, got %b", $realtime,
                             want.done, u16_out.stream_done);
                end
            end
        end
    end

    // Main sequence: reset, directed table, then four idling mixes.
    initial begin : stimulus
        int i;
        i_rst_n          = 1'b0;
        u8_in.valid      <= 1'b0;
        u8_in.in_byte    <= 8'h00;
        u8_in.stream_end <= 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < N_DIRECTED; i++) begin
            send_byte(DIRECTED[i]);
        end
        wait_for_units();

        // No idling on either side.
        send_random(48);

        // Sender idle about half the time.
        send_idle_pct = 53;
        send_random(48);

        // Receiver stalls, with one long hold-off while bytes keep coming.
        send_idle_pct = 0;
        rx_stall_pct  <= 53;
        hold_request  <= 1'b1;
        send_random(48);
        wait_for_units();

        // Both sides idle now and then.
        send_idle_pct = 26;
        rx_stall_pct  <= 26;
        send_random(48);

        wait_for_units();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_units.size() != 0) begin
            error_count++;
            $display("%0t: %0d expected units never came out", $realtime,
                     expected_units.size());
        end

        $display("Run: %0d bytes in (%0d stream ends), %0d code units checked, %0d pairs.",
                 bytes_sent, ends_sent, units_checked, pairs_seen);
        $display("Mixes: no idling, sender gaps, receiver stalls with long hold, both.");
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin : watchdog
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> filelist.f
design/u8u16_pkg.sv
design/u8u16_in_if.sv
design/u8u16_out_if.sv
design/utf8_to_utf16_transcoder.sv
sim/utf8_to_utf16_transcoder_tb.sv
